// ===== rtl/core/lcal_pkg.sv =====
package lcal_pkg;

    localparam int NODE_W  = 10;
    localparam int DEPTH_W = 11;
    localparam int STEP_W  = 5;

    typedef logic [NODE_W-1:0]  node_t;
    typedef logic [DEPTH_W-1:0] depth_t;
    typedef logic [STEP_W-1:0]  step_t;

    localparam depth_t DEPTH_MAX = '1;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_DEP,
        RD_ANC
    } rd_op_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_LOAD0,
        WR_LOADK
    } wr_op_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ORDER,
        OP_LIFT,
        OP_LDSTEP,
        OP_LVL_TOP,
        OP_PAIR,
        OP_OUT_A,
        OP_OUT_ANC,
        OP_OUT_ZERO
    } dp_op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_OOR,
        C_QUERY,
        C_LOAD,
        C_SINGLE,
        C_LD_MORE,
        C_LVL_MORE,
        C_EQ,
        C_LVL_NZ
    } cond_t;

    typedef struct packed {
        rd_op_t rd;
        wr_op_t wr;
        dp_op_t op;
        logic   emit;
        logic   done;
        cond_t  cond;
        step_t  target;
    } cw_t;

    typedef struct packed {
        logic oor;
        logic query;
        logic single;
        logic ld_more;
        logic lvl_more;
        logic eq;
        logic lvl_nz;
    } flags_t;

    // microprogram addresses
    localparam step_t S_START   = 5'd0;
    localparam step_t S_DISP    = 5'd1;
    localparam step_t S_LD0     = 5'd2;
    localparam step_t S_LDR     = 5'd3;
    localparam step_t S_LDW     = 5'd4;
    localparam step_t S_END     = 5'd5;
    localparam step_t S_QDEP    = 5'd6;
    localparam step_t S_LIFT    = 5'd7;
    localparam step_t S_LIFT2   = 5'd8;
    localparam step_t S_EQ      = 5'd9;
    localparam step_t S_PR      = 5'd10;
    localparam step_t S_PU      = 5'd11;
    localparam step_t S_FIN     = 5'd12;
    localparam step_t S_RES_ANC = 5'd13;
    localparam step_t S_RES_A   = 5'd14;
    localparam step_t S_OOR     = 5'd15;
    localparam step_t S_OOR_Q   = 5'd16;

    localparam cw_t CW_NOP = '{
        rd:     RD_NONE,
        wr:     WR_NONE,
        op:     OP_NONE,
        emit:   1'b0,
        done:   1'b0,
        cond:   C_NEVER,
        target: S_START
    };

    // control store
    function automatic cw_t ucode(input step_t s);
        cw_t w;
        w = CW_NOP;
        unique case (s)
            S_START:
            begin
                w.rd     = RD_DEP;
                w.cond   = C_OOR;
                w.target = S_OOR;
            end
            S_DISP:
            begin
                w.cond   = C_QUERY;
                w.target = S_QDEP;
            end
            S_LD0:
            begin
                w.wr     = WR_LOAD0;
                w.cond   = C_SINGLE;
                w.target = S_END;
            end
            S_LDR:
            begin
                w.rd = RD_ANC;
            end
            S_LDW:
            begin
                w.wr     = WR_LOADK;
                w.op     = OP_LDSTEP;
                w.cond   = C_LD_MORE;
                w.target = S_LDR;
            end
            S_END:
            begin
                w.done = 1'b1;
            end
            S_QDEP:
            begin
                w.op = OP_ORDER;
            end
            S_LIFT:
            begin
                w.rd = RD_ANC;
            end
            S_LIFT2:
            begin
                w.op     = OP_LIFT;
                w.cond   = C_LVL_MORE;
                w.target = S_LIFT;
            end
            S_EQ:
            begin
                w.op     = OP_LVL_TOP;
                w.cond   = C_EQ;
                w.target = S_RES_A;
            end
            S_PR:
            begin
                w.rd = RD_ANC;
            end
            S_PU:
            begin
                w.op     = OP_PAIR;
                w.cond   = C_LVL_NZ;
                w.target = S_PR;
            end
            S_FIN:
            begin
                w.rd = RD_ANC;
            end
            S_RES_ANC:
            begin
                w.op   = OP_OUT_ANC;
                w.emit = 1'b1;
                w.done = 1'b1;
            end
            S_RES_A:
            begin
                w.op   = OP_OUT_A;
                w.emit = 1'b1;
                w.done = 1'b1;
            end
            S_OOR:
            begin
                w.cond   = C_LOAD;
                w.target = S_END;
            end
            S_OOR_Q:
            begin
                w.op   = OP_OUT_ZERO;
                w.emit = 1'b1;
                w.done = 1'b1;
            end
            default:
            begin
                w.done = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/lcal_seq.sv =====
module lcal_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            out_blocked,
    input  lcal_pkg::flags_t flags,
    output lcal_pkg::cw_t   cw,
    output logic            busy
);
    import lcal_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  busy_reg;
    logic  busy_next;
    cw_t   word;
    logic  hold;
    logic  fire;
    logic  jump;

    assign word = ucode(step_reg);
    // a result step waits while the output register is full and stalled
    assign hold = word.emit && out_blocked;
    assign fire = busy_reg && !hold;
    assign cw   = fire ? word : CW_NOP;
    assign busy = busy_reg;

    always_comb
    begin
        unique case (word.cond)
            C_NEVER:    jump = 1'b0;
            C_OOR:      jump = flags.oor;
            C_QUERY:    jump = flags.query;
            C_LOAD:     jump = !flags.query;
            C_SINGLE:   jump = flags.single;
            C_LD_MORE:  jump = flags.ld_more;
            C_LVL_MORE: jump = flags.lvl_more;
            C_EQ:       jump = flags.eq;
            C_LVL_NZ:   jump = flags.lvl_nz;
            default:    jump = 1'b0;
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            step_next = S_START;
            busy_next = 1'b1;
        end
        else if (fire)
        begin
            if (word.done)
            begin
                busy_next = 1'b0;
            end
            else if (jump)
            begin
                step_next = word.target;
            end
            else
            begin
                step_next = step_reg + step_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_START;
            busy_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

endmodule

// ===== rtl/core/lcal_dp.sv =====
module lcal_dp #(
    parameter int MAX_NODES  = 1024,
    parameter int LOG_LEVELS = 10
) (
    input  logic             clk,
    input  logic             start,
    input  logic             func,
    input  lcal_pkg::node_t  node_a,
    input  lcal_pkg::node_t  node_b,
    input  lcal_pkg::cw_t    cw,
    output lcal_pkg::flags_t flags,
    output lcal_pkg::node_t  result
);
    import lcal_pkg::*;

    localparam int AW      = $clog2(MAX_NODES);
    localparam int ENTRIES = MAX_NODES * LOG_LEVELS;
    localparam int ADW     = $clog2(ENTRIES);
    localparam int LVW     = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;

    node_t           a_reg;
    node_t           b_reg;
    logic            func_reg;
    depth_t          diff_reg;
    logic [LVW-1:0]  lvl_reg;

    node_t           anc_mem [ENTRIES];
    depth_t          dep_mem [MAX_NODES];
    node_t           anc0_reg;
    node_t           anc1_reg;
    depth_t          dep0_reg;
    depth_t          dep1_reg;

    logic [ADW-1:0]  base_a;
    logic [ADW-1:0]  base_b;
    logic [ADW-1:0]  lvl_ext;
    logic [ADW-1:0]  rd_addr0;
    logic [ADW-1:0]  rd_addr1;
    logic [ADW-1:0]  wr_addr;
    node_t           wr_data;
    logic [AW-1:0]   idx_a;
    logic [AW-1:0]   idx_b;
    depth_t          new_depth;

    // entry (node, level) sits at node * LOG_LEVELS + level
    assign base_a   = ADW'(ADW'(a_reg) * ADW'(LOG_LEVELS));
    assign base_b   = ADW'(ADW'(b_reg) * ADW'(LOG_LEVELS));
    assign lvl_ext  = ADW'(lvl_reg);
    assign rd_addr0 = base_a + lvl_ext;
    assign rd_addr1 = base_b + lvl_ext;
    assign idx_a    = AW'(a_reg);
    assign idx_b    = AW'(b_reg);

    always_comb
    begin
        if (cw.wr == WR_LOADK)
        begin
            wr_addr = base_a + lvl_ext + ADW'(1);
            wr_data = anc1_reg;
        end
        else
        begin
            wr_addr = base_a;
            wr_data = b_reg;
        end
    end

    // a root sits at depth 1; otherwise one below its parent, saturating
    always_comb
    begin
        if (a_reg == b_reg)
            new_depth = depth_t'(1);
        else if (dep1_reg == DEPTH_MAX)
            new_depth = DEPTH_MAX;
        else
            new_depth = dep1_reg + depth_t'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cw.wr != WR_NONE)
            anc_mem[wr_addr] <= wr_data;
        if (cw.rd == RD_ANC)
        begin
            anc0_reg <= anc_mem[rd_addr0];
            anc1_reg <= anc_mem[rd_addr1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cw.wr == WR_LOAD0)
            dep_mem[idx_a] <= new_depth;
        if (cw.rd == RD_DEP)
        begin
            dep0_reg <= dep_mem[idx_a];
            dep1_reg <= dep_mem[idx_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= node_a;
            b_reg    <= node_b;
            func_reg <= func;
            lvl_reg  <= '0;
        end
        else
        begin
            unique case (cw.op)
                OP_ORDER:
                begin
                    // keep the deeper node in a_reg
                    if (dep0_reg < dep1_reg)
                    begin
                        a_reg    <= b_reg;
                        b_reg    <= a_reg;
                        diff_reg <= dep1_reg - dep0_reg;
                    end
                    else
                    begin
                        diff_reg <= dep0_reg - dep1_reg;
                    end
                end
                OP_LIFT:
                begin
                    if (diff_reg[0])
                        a_reg <= anc0_reg;
                    diff_reg <= diff_reg >> 1;
                    lvl_reg  <= lvl_reg + LVW'(1);
                end
                OP_LDSTEP:
                begin
                    b_reg   <= anc1_reg;
                    lvl_reg <= lvl_reg + LVW'(1);
                end
                OP_LVL_TOP:
                begin
                    lvl_reg <= LVW'(LOG_LEVELS - 1);
                end
                OP_PAIR:
                begin
                    if (anc0_reg != anc1_reg)
                    begin
                        a_reg <= anc0_reg;
                        b_reg <= anc1_reg;
                    end
                    if (lvl_reg != '0)
                        lvl_reg <= lvl_reg - LVW'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign flags.oor      = (32'(a_reg) >= MAX_NODES) || (32'(b_reg) >= MAX_NODES);
    assign flags.query    = func_reg;
    assign flags.single   = (LOG_LEVELS == 1);
    assign flags.ld_more  = (32'(lvl_reg) + 32'd2) < LOG_LEVELS;
    assign flags.lvl_more = (32'(lvl_reg) + 32'd1) < LOG_LEVELS;
    assign flags.eq       = (a_reg == b_reg);
    assign flags.lvl_nz   = (lvl_reg != '0);

    always_comb
    begin
        unique case (cw.op)
            OP_OUT_A:   result = a_reg;
            OP_OUT_ANC: result = anc0_reg;
            default:    result = '0;
        endcase
    end

endmodule

// ===== rtl/core/lowest_common_ancestor_lifting_core.sv =====
// Binary-lifting lowest common ancestor engine. A request with func = 0 loads node_a with
// parent node_b (a node that is its own parent is a root); parents must be loaded before
// their children. A request with func = 1 returns the lowest common ancestor of node_a and
// node_b on ancestor. Requests are handled one at a time by a microcoded sequencer over a
// two-read, one-write ancestor memory and a depth memory; each level takes a read step and
// an update step because the next address comes from the data just read. A query finishes
// early when lifting alone reaches the ancestor. A node at or above MAX_NODES makes a load
// do nothing and a query return 0. The memories are not cleared, so no clearing pass
// follows reset.
module lowest_common_ancestor_lifting_core #(
    parameter int MAX_NODES  = 1024,
    parameter int LOG_LEVELS = 10
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            func,
    input  lcal_pkg::node_t node_a,
    input  lcal_pkg::node_t node_b,
    output logic            out_valid,
    input  logic            out_stall,
    output lcal_pkg::node_t ancestor
);
    import lcal_pkg::*;

    logic   busy;
    logic   start;
    logic   out_blocked;
    cw_t    cw;
    flags_t flags;
    node_t  result;
    logic   out_valid_reg;
    logic   out_valid_next;
    node_t  res_reg;

    assign in_stall    = busy;
    assign start       = in_valid && !busy;
    assign out_blocked = out_valid_reg && out_stall;

    lcal_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .out_blocked (out_blocked),
        .flags       (flags),
        .cw          (cw),
        .busy        (busy)
    );

    lcal_dp #(
        .MAX_NODES  (MAX_NODES),
        .LOG_LEVELS (LOG_LEVELS)
    ) u_dp (
        .clk    (clk),
        .start  (start),
        .func   (func),
        .node_a (node_a),
        .node_b (node_b),
        .cw     (cw),
        .flags  (flags),
        .result (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cw.emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cw.emit)
            res_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign ancestor  = res_reg;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted but sequencer not busy");

    a_emit_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        cw.emit |-> !(out_valid_reg && out_stall))
        else $error("result written over a stalled one");

    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cw.emit))
        else $error("output valid without a result step");
`endif

endmodule
